### hw/rtl/lz77_rle_gamma_decompressor_macros.svh
// assertion macros for the decompressor top level
// no dependencies
`ifndef LZ77_RLE_GAMMA_DECOMPRESSOR_MACROS_SVH
`define LZ77_RLE_GAMMA_DECOMPRESSOR_MACROS_SVH
// implication checked at every clock edge outside reset
`define LRG_ASSERT_IMP(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("assertion failed");
// implication checked in the cycle after the condition
`define LRG_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

### hw/rtl/lrgd_pkg.sv
// shared types, codes and constants of the decompressor
// no dependencies
package lrgd_pkg;
    localparam int HistoryDepth = 65536;
    localparam int HistAw = $clog2(HistoryDepth);
    localparam int RankDepth = 31;
    localparam int RankAw = $clog2(RankDepth + 1);

    localparam logic [2:0] ST_BYTE = 3'd0;
    localparam logic [2:0] ST_NEED = 3'd1;
    localparam logic [2:0] ST_END = 3'd2;
    localparam logic [2:0] ST_ACC = 3'd3;
    localparam logic [2:0] ST_REF = 3'd4;

    typedef enum logic [4:0] {
        PH_HDR, PH_ESC, PH_LIT, PH_LEN_P, PH_LEN_S, PH_SEL1, PH_SEL2, PH_NEWESC,
        PH_RLEN_P, PH_RLEN_S, PH_RLONG, PH_RMSB_P, PH_RMSB_S, PH_RANK_P, PH_RANK_S,
        PH_RANK_X, PH_RUN, PH_HI_P, PH_HI_S, PH_EXTRA, PH_OFFLO, PH_COPY, PH_END
    } phase_t;

    typedef enum logic [2:0] {
        CMD_NONE, CMD_STEP, CMD_HDR, CMD_HOLD, CMD_EMIT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] data;
    } dp_cmd_t;

    typedef struct packed {
        logic       done;
        logic       more;
        logic [2:0] status;
        logic [7:0] out_byte;
        logic       ended;
    } dp_stat_t;
endpackage

### hw/rtl/lrgd_datapath.sv
// decoding datapath: bit shifter, token fields, rank table and history memory
// depends on lrgd_pkg
module lrgd_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  lrgd_pkg::dp_cmd_t  cmd,
    output lrgd_pkg::dp_stat_t stat
);
    import lrgd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [5:0]  hc_reg, hc_next;
    logic [7:0]  esc_reg, esc_next;
    logic [3:0]  escb_reg, escb_next, glim_reg, glim_next, offb_reg, offb_next;
    logic [7:0]  srl_reg, srl_next;
    logic [7:0]  sh_reg, sh_next;
    logic [8:0]  held_reg, held_next;
    logic [7:0]  acc_reg, acc_next;
    logic [3:0]  bc_reg, bc_next;
    logic [16:0] run_reg, run_next;
    logic [7:0]  rb_reg, rb_next;
    logic [15:0] cp_reg, cp_next, wp_reg, wp_next;
    logic [7:0]  rank_mem [RankDepth];
    logic [7:0]  hist_mem [HistoryDepth];
    logic [7:0]  hist_rd_reg;
    logic        rd_pend_reg, rd_pend_next;
    logic        rk_we, h_we;
    logic [7:0]  h_wd;
    logic [2:0]  status_next;
    logic [7:0]  ob_next;
    logic        done_next, more_next;
    logic [2:0]  st_reg;
    logic [7:0]  ob_reg;
    logic        done_reg, more_reg;

    logic        bit_ok, bit_v;
    logic [7:0]  sh_take;
    logic [8:0]  held_take;
    logic [7:0]  acc_sh;
    logic [3:0]  lim;
    logic [7:0]  b8;
    logic [7:0]  rank_idx;
    logic [15:0] hi256;

    always_comb begin
        bit_ok = 1'b1;
        bit_v = sh_reg[7];
        sh_take = {sh_reg[6:0], 1'b0};
        held_take = held_reg;
        if (sh_reg[6:0] == 7'd0) begin
            bit_ok = held_reg[8];
            bit_v = held_reg[7];
            sh_take = {held_reg[6:0], 1'b1};
            held_take = 9'd0;
        end
        acc_sh = {acc_reg[6:0], bit_v};
        b8 = cmd.data;
        rank_idx = acc_reg - 8'd1;
        hi256 = {rb_reg + 8'd1, 8'd0};
    end

    always_comb begin
        phase_next = phase_reg; hc_next = hc_reg; esc_next = esc_reg;
        escb_next = escb_reg; glim_next = glim_reg; offb_next = offb_reg;
        srl_next = srl_reg; sh_next = sh_reg; held_next = held_reg;
        acc_next = acc_reg; bc_next = bc_reg; run_next = run_reg; rb_next = rb_reg;
        cp_next = cp_reg; wp_next = wp_reg;
        rk_we = 1'b0; h_we = 1'b0; h_wd = 8'd0; lim = 4'd0;
        status_next = ST_BYTE; ob_next = 8'd0; done_next = 1'b0; more_next = 1'b0;
        rd_pend_next = 1'b0;
        unique case (cmd.op)
            CMD_HDR: begin
                done_next = 1'b1;
                if (phase_reg == PH_HDR) begin
                    status_next = ST_ACC;
                    hc_next = hc_reg + 6'd1;
                    if (hc_reg < 6'd16) begin
                        if (hc_reg == 6'd6) esc_next = b8;
                        if (hc_reg == 6'd9) escb_next = (b8 > 8'd8) ? 4'd8 : b8[3:0];
                        if (hc_reg == 6'd10)
                            glim_next = (b8 < 8'd2) ? 4'd2 : ((b8 > 8'd8) ? 4'd8 : b8[3:0]);
                        if (hc_reg == 6'd11) srl_next = b8;
                        if (hc_reg == 6'd12) offb_next = (b8 > 8'd8) ? 4'd8 : b8[3:0];
                        if (hc_reg == 6'd15) begin
                            acc_next = (b8 > 8'(RankDepth)) ? 8'(RankDepth) : b8;
                            if (b8 == 8'd0) begin
                                phase_next = PH_ESC; acc_next = 8'd0; bc_next = 4'd0;
                            end
                        end
                    end else begin
                        rk_we = 1'b1;
                        if ({2'd0, hc_next} - 8'd16 >= acc_reg) begin
                            phase_next = PH_ESC; acc_next = 8'd0; bc_next = 4'd0;
                        end
                    end
                end else if (phase_reg == PH_END || held_reg[8]) begin
                    status_next = ST_REF;
                end else begin
                    held_next = {1'b1, b8};
                    status_next = ST_ACC;
                end
            end
            CMD_EMIT: begin
                done_next = 1'b1;
                h_we = 1'b1;
                h_wd = hist_rd_reg;
                ob_next = hist_rd_reg;
                wp_next = wp_reg + 16'd1;
                cp_next = cp_reg + 16'd1;
            end
            CMD_STEP: begin
                done_next = 1'b1;
                more_next = 1'b1;
                unique case (phase_reg)
                    PH_HDR: begin more_next = 1'b0; status_next = ST_NEED; end
                    PH_ESC, PH_LIT, PH_NEWESC, PH_RLONG, PH_RANK_X, PH_EXTRA,
                    PH_OFFLO: begin
                        unique case (phase_reg)
                            PH_ESC, PH_NEWESC: lim = escb_reg;
                            PH_LIT: lim = 4'd8 - escb_reg;
                            PH_RLONG: lim = 4'd9 - glim_reg;
                            PH_RANK_X: lim = 4'd3;
                            PH_EXTRA: lim = offb_reg;
                            default: lim = 4'd8;
                        endcase
                        if (bc_reg < lim) begin
                            if (!bit_ok) begin
                                more_next = 1'b0; status_next = ST_NEED;
                            end else begin
                                sh_next = sh_take; held_next = held_take;
                                acc_next = acc_sh; bc_next = bc_reg + 4'd1;
                            end
                        end else begin
                            unique case (phase_reg)
                                PH_ESC: begin
                                    if (acc_reg != esc_reg) begin
                                        phase_next = PH_LIT; bc_next = 4'd0;
                                    end else begin
                                        phase_next = PH_LEN_P; acc_next = 8'd1;
                                        bc_next = 4'd1;
                                    end
                                end
                                PH_LIT: begin
                                    more_next = 1'b0; ob_next = acc_reg;
                                    h_we = 1'b1; h_wd = acc_reg; wp_next = wp_reg + 16'd1;
                                    phase_next = PH_ESC; acc_next = 8'd0; bc_next = 4'd0;
                                end
                                PH_NEWESC: begin
                                    esc_next = acc_reg; acc_next = esc_reg;
                                    bc_next = 4'd0; phase_next = PH_LIT;
                                end
                                PH_RLONG: begin
                                    run_next = {9'd0, acc_reg}; phase_next = PH_RMSB_P;
                                    acc_next = 8'd1; bc_next = 4'd1;
                                end
                                PH_RANK_X: begin rb_next = acc_reg; phase_next = PH_RUN; end
                                PH_EXTRA: begin
                                    rb_next = acc_reg; acc_next = 8'd0; bc_next = 4'd0;
                                    phase_next = PH_OFFLO;
                                end
                                default: begin
                                    cp_next = wp_reg + {8'd0, acc_reg} - hi256;
                                    run_next = run_reg + 17'd1; phase_next = PH_COPY;
                                end
                            endcase
                        end
                    end
                    PH_LEN_P, PH_RLEN_P, PH_RMSB_P, PH_RANK_P, PH_HI_P: begin
                        if (!bit_ok) begin
                            more_next = 1'b0; status_next = ST_NEED;
                        end else begin
                            sh_next = sh_take; held_next = held_take;
                            if (!bit_v) phase_next = phase_t'(phase_reg + 5'd1);
                            else begin
                                bc_next = bc_reg + 4'd1;
                                if (bc_reg + 4'd1 >= glim_reg)
                                    phase_next = phase_t'(phase_reg + 5'd1);
                            end
                        end
                    end
                    PH_LEN_S, PH_RLEN_S, PH_RMSB_S, PH_RANK_S, PH_HI_S: begin
                        if (bc_reg > 4'd1) begin
                            if (!bit_ok) begin
                                more_next = 1'b0; status_next = ST_NEED;
                            end else begin
                                sh_next = sh_take; held_next = held_take;
                                acc_next = acc_sh; bc_next = bc_reg - 4'd1;
                            end
                        end else begin
                            unique case (phase_reg)
                                PH_LEN_S: begin
                                    run_next = {9'd0, acc_reg};
                                    if (acc_reg >= 8'd2) begin
                                        phase_next = PH_HI_P; acc_next = 8'd1; bc_next = 4'd1;
                                    end else phase_next = PH_SEL1;
                                end
                                PH_RLEN_S: begin
                                    if (acc_reg < srl_reg) begin
                                        run_next = {9'd0, acc_reg} + 17'd1;
                                        phase_next = PH_RANK_P; acc_next = 8'd1; bc_next = 4'd1;
                                    end else begin bc_next = 4'd0; phase_next = PH_RLONG; end
                                end
                                PH_RMSB_S: begin
                                    run_next = run_reg + 17'd1 + {1'b0, acc_reg - 8'd1, 8'd0};
                                    phase_next = PH_RANK_P; acc_next = 8'd1; bc_next = 4'd1;
                                end
                                PH_RANK_S: begin
                                    if (acc_reg < 8'd32) begin
                                        rb_next = (rank_idx < 8'(RankDepth))
                                            ? rank_mem[rank_idx[RankAw-1:0]] : 8'd0;
                                        phase_next = PH_RUN;
                                    end else begin bc_next = 4'd0; phase_next = PH_RANK_X; end
                                end
                                default: begin
                                    if (acc_reg == 8'({srl_reg, 1'b0} - 9'd1)) begin
                                        phase_next = PH_END;
                                    end else begin
                                        acc_next = acc_reg - 8'd1; bc_next = 4'd0;
                                        phase_next = PH_EXTRA;
                                    end
                                end
                            endcase
                        end
                    end
                    PH_SEL1, PH_SEL2: begin
                        if (!bit_ok) begin
                            more_next = 1'b0; status_next = ST_NEED;
                        end else begin
                            sh_next = sh_take; held_next = held_take;
                            if (phase_reg == PH_SEL1) begin
                                if (!bit_v) begin
                                    rb_next = 8'd0; acc_next = 8'd0; bc_next = 4'd0;
                                    phase_next = PH_OFFLO;
                                end else phase_next = PH_SEL2;
                            end else begin
                                if (!bit_v) begin
                                    acc_next = 8'd0; bc_next = 4'd0; phase_next = PH_NEWESC;
                                end else begin
                                    phase_next = PH_RLEN_P; acc_next = 8'd1; bc_next = 4'd1;
                                end
                            end
                        end
                    end
                    PH_RUN, PH_COPY: begin
                        if (run_reg == 17'd0) begin
                            phase_next = PH_ESC; acc_next = 8'd0; bc_next = 4'd0;
                        end else if (phase_reg == PH_RUN) begin
                            more_next = 1'b0; ob_next = rb_reg;
                            h_we = 1'b1; h_wd = rb_reg; wp_next = wp_reg + 16'd1;
                            run_next = run_reg - 17'd1;
                        end else begin
                            done_next = 1'b0; more_next = 1'b0; rd_pend_next = 1'b1;
                            run_next = run_reg - 17'd1;
                        end
                    end
                    default: begin
                        more_next = 1'b0; status_next = ST_END; phase_next = PH_END;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR; hc_reg <= '0; esc_reg <= '0; escb_reg <= '0;
            glim_reg <= '0; offb_reg <= '0; srl_reg <= '0; sh_reg <= 8'h80;
            held_reg <= '0; acc_reg <= '0; bc_reg <= '0; run_reg <= '0; rb_reg <= '0;
            cp_reg <= '0; wp_reg <= '0; done_reg <= 1'b0; more_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next; hc_reg <= hc_next; esc_reg <= esc_next;
            escb_reg <= escb_next; glim_reg <= glim_next; offb_reg <= offb_next;
            srl_reg <= srl_next; sh_reg <= sh_next; held_reg <= held_next;
            acc_reg <= acc_next; bc_reg <= bc_next; run_reg <= run_next; rb_reg <= rb_next;
            cp_reg <= cp_next; wp_reg <= wp_next; done_reg <= done_next;
            more_reg <= more_next; rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        st_reg <= status_next;
        ob_reg <= ob_next;
        if (rk_we && hc_reg < 6'(16 + RankDepth))
            rank_mem[5'(hc_reg - 6'd16)] <= b8;
        if (h_we) hist_mem[wp_reg[HistAw-1:0]] <= h_wd;
        hist_rd_reg <= hist_mem[cp_reg[HistAw-1:0]];
    end

    assign stat.done = done_reg;
    assign stat.more = more_reg | rd_pend_reg;
    assign stat.status = st_reg;
    assign stat.out_byte = ob_reg;
    assign stat.ended = (phase_reg == PH_END);
endmodule

### hw/rtl/lrgd_ctrl.sv
// handshake controller: accepts beats, sequences datapath steps, holds the result
// depends on lrgd_pkg
module lrgd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [7:0]         s_in_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [7:0]         m_out_byte,
    output lrgd_pkg::dp_cmd_t  cmd,
    input  lrgd_pkg::dp_stat_t stat
);
    import lrgd_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_WORK, S_EMIT, S_WAIT} ctrl_state_t;

    ctrl_state_t state_reg;
    logic        m_valid_reg;
    logic [2:0]  status_reg;
    logic [7:0]  byte_reg;
    logic        finish;

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign finish = (state_reg == S_WORK || state_reg == S_EMIT) && stat.done && !stat.more;

    always_comb begin
        cmd.op = CMD_NONE;
        cmd.data = s_in_byte;
        unique case (state_reg)
            S_IDLE: if (s_valid && s_ready) cmd.op = s_kind ? CMD_STEP : CMD_HDR;
            S_WORK: if (stat.done && stat.more) cmd.op = CMD_STEP;
            S_WAIT: cmd.op = CMD_EMIT;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_valid && s_ready) state_reg <= S_WORK;
                S_WORK: begin
                    if (stat.done && !stat.more) begin
                        state_reg <= S_IDLE;
                    end else if (!stat.done && stat.more) begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT: state_reg <= S_EMIT;
                default: if (stat.done) state_reg <= S_IDLE;
            endcase
            if (finish) begin
                m_valid_reg <= 1'b1;
                status_reg <= stat.status;
                byte_reg <= stat.out_byte;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_status = status_reg;
    assign m_out_byte = byte_reg;
endmodule

### hw/rtl/lz77_rle_gamma_decompressor.sv
// Streaming LZ77/RLE decompressor with escape-coded literals and gamma lengths.
// Each input beat either delivers one compressed byte (kind 0) or requests one
// output byte (kind 1); every beat yields exactly one result beat with a status.
// A request decodes compressed bits one at a time in the single-bit shifter loop
// until it yields an output byte or needs more input; back-copy bytes read the
// history through a registered memory port.
// depends on lrgd_pkg, lrgd_ctrl, lrgd_datapath and the macros header
`include "lz77_rle_gamma_decompressor_macros.svh"
module lz77_rle_gamma_decompressor (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [7:0] m_out_byte
);
    import lrgd_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lrgd_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_kind, .s_in_byte,
        .m_valid, .m_ready, .m_status, .m_out_byte, .cmd, .stat
    );

    lrgd_datapath u_dp (.aclk, .aresetn, .cmd, .stat);

    `LRG_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, m_valid && !m_ready, !s_ready)
    `LRG_ASSERT_NEXT(a_end_sticky, aclk, aresetn, stat.ended, stat.ended)
    `LRG_ASSERT_IMP(a_status_range, aclk, aresetn, m_valid, m_status <= ST_REF)
endmodule
